@@ hdl/swm_pkg.sv @@
// shared constants and types for the sliding window maximum block
package swm_pkg;

  localparam int unsigned WINDOW_MAX = 64;
  localparam int unsigned IDX_W      = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned POS_W      = IDX_W + 1;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned WIN_W      = 7;
  localparam int unsigned ENTRY_W    = SAMPLE_W + POS_W;

  // memory access request from the sequencer
  typedef struct packed {
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
  } ram_req_t;

  // result handed to the output register
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] data;
  } out_load_t;

endpackage

@@ hdl/swm_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module swm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/swm_seq.sv @@
// deque sequencer: front aging, back pruning, append and front readout
module swm_seq import swm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                start_i,
  input  logic [WIN_W-1:0]    window_size_i,
  input  logic [ENTRY_W-1:0]  rd_data_i,
  output ram_req_t            ram_req_o,
  input  logic                out_free_i,
  output out_load_t           out_load_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRONT_REQ,
    S_FRONT_CHK,
    S_BACK_REQ,
    S_BACK_CHK,
    S_APPEND,
    S_OUT_REQ,
    S_OUT_CHK
  } state_e;

  state_e              state_q, state_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    pos_ctr_q, pos_ctr_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    front_q, front_d;
  logic [CNT_W-1:0]    fill_q, fill_d;

  logic [CNT_W-1:0]    win;
  logic [CNT_W-1:0]    fill_next;
  logic [IDX_W-1:0]    back_idx;
  logic [POS_W-1:0]    age;
  logic [SAMPLE_W-1:0] rd_value;
  logic [POS_W-1:0]    rd_pos;
  logic                full;

  // effective window: zero reads as one, large values saturate
  always_comb begin
    if (window_size_i == '0) begin
      win = CNT_W'(1);
    end else if (CNT_W'(window_size_i) > CNT_W'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = CNT_W'(window_size_i);
    end
  end

  assign rd_value  = rd_data_i[SAMPLE_W-1:0];
  assign rd_pos    = rd_data_i[ENTRY_W-1:SAMPLE_W];
  assign back_idx  = front_q + count_q[IDX_W-1:0] - IDX_W'(1);
  assign age       = pos_q - rd_pos;
  assign full      = (count_q == CNT_W'(WINDOW_MAX));
  assign fill_next = (fill_q < win) ? fill_q + CNT_W'(1) : win;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    sample_d  = sample_q;
    pos_d     = pos_q;
    pos_ctr_d = pos_ctr_q;
    count_d   = count_q;
    front_d   = front_q;
    fill_d    = fill_q;

    ram_req_o         = '0;
    ram_req_o.wr_data = {pos_q, sample_q};
    out_load_o.valid  = 1'b0;
    out_load_o.data   = rd_value;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          sample_d = sample_i;
          if (start_i) begin
            count_d = '0;
            front_d = '0;
            fill_d  = '0;
            pos_d   = '0;
          end else begin
            pos_d   = pos_ctr_q;
          end
          state_d = S_FRONT_REQ;
        end
      end
      S_FRONT_REQ: begin
        if (count_q == '0) begin
          state_d = S_APPEND;
        end else begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = front_q;
          state_d = S_FRONT_CHK;
        end
      end
      S_FRONT_CHK: begin
        if (CNT_W'(age) >= win) begin
          front_d = front_q + IDX_W'(1);
          count_d = count_q - CNT_W'(1);
          state_d = S_FRONT_REQ;
        end else begin
          state_d = S_BACK_REQ;
        end
      end
      S_BACK_REQ: begin
        if (count_q == '0) begin
          state_d = S_APPEND;
        end else begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = back_idx;
          state_d = S_BACK_CHK;
        end
      end
      S_BACK_CHK: begin
        // ties go to the newer sample
        if (rd_value <= sample_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_BACK_REQ;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        ram_req_o.wr_en = 1'b1;
        if (full) begin
          // drop the oldest entry, the new one takes its slot
          front_d           = front_q + IDX_W'(1);
          ram_req_o.wr_addr = front_q;
        end else begin
          count_d           = count_q + CNT_W'(1);
          ram_req_o.wr_addr = front_q + count_q[IDX_W-1:0];
        end
        pos_ctr_d = pos_q + POS_W'(1);
        fill_d    = fill_next;
        state_d   = (fill_next >= win) ? S_OUT_REQ : S_IDLE;
      end
      S_OUT_REQ: begin
        ram_req_o.rd_en   = 1'b1;
        ram_req_o.rd_addr = front_q;
        state_d = S_OUT_CHK;
      end
      S_OUT_CHK: begin
        if (out_free_i) begin
          out_load_o.valid = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_ctr_q <= '0;
      count_q   <= '0;
      front_q   <= '0;
      fill_q    <= '0;
      pos_q     <= '0;
      sample_q  <= '0;
    end else begin
      state_q   <= state_d;
      pos_ctr_q <= pos_ctr_d;
      count_q   <= count_d;
      front_q   <= front_d;
      fill_q    <= fill_d;
      pos_q     <= pos_d;
      sample_q  <= sample_d;
    end
  end

endmodule

@@ hdl/swm_out.sv @@
// output holding register for the result stream
module swm_out import swm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  out_load_t           load_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [SAMPLE_W-1:0] data_o
);

  logic                valid_q, valid_d;
  logic [SAMPLE_W-1:0] data_q, data_d;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (valid_q && ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i.valid) begin
      valid_d = 1'b1;
      data_d  = load_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/sliding_window_maximum_core.sv @@
// Sliding window maximum over a stream of 24-bit unsigned samples. Each request carries
// one sample and a start flag that clears the window history first. After the window
// first fills, every sample gives one result: the maximum of the last window_size
// samples (window_size 0 acts as 1, above 64 saturates at 64; for a new size to apply from
// the next sample, the user must write it only while idle, which the block does not enforce).
// Candidates live in a 64-entry single-read-port memory of value and position; each memory
// read has an issue state and a compare state. A sample is taken in idle, then ages entries
// out of the front, prunes entries no larger than itself from the back, appends itself and,
// once the window has filled, reads the front entry out as its result; the readout also
// waits while the previous result still sits unaccepted in the output register. The result
// register lets the next sample enter while a result waits to be taken.
module sliding_window_maximum_core import swm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // [23:0] sample
  input  logic [0:0]          s_axis_tuser,   // [0] start_sequence
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // [23:0] window_max
  input  logic                cfg_we_i,
  input  logic [WIN_W-1:0]    cfg_wdata_i     // window_size
);

  logic [WIN_W-1:0]   window_size_q;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] rd_data;
  out_load_t          out_load;
  logic               out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WIN_W'(1);
    end else if (cfg_we_i) begin
      window_size_q <= cfg_wdata_i;
    end
  end

  swm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .sample_i      (s_axis_tdata[SAMPLE_W-1:0]),
    .start_i       (s_axis_tuser[0]),
    .window_size_i (window_size_q),
    .rd_data_i     (rd_data),
    .ram_req_o     (ram_req),
    .out_free_i    (out_free),
    .out_load_o    (out_load)
  );

  swm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (rd_data)
  );

  swm_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

@@ hdl/swm_checker.sv @@
// port-level checks for the sliding window maximum block, bound to the top level
module swm_checker import swm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [23:0]      s_axis_tdata,
  input logic [0:0]       s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [23:0]      m_axis_tdata,
  input logic             cfg_we_i,
  input logic [WIN_W-1:0] cfg_wdata_i
);

  // one request at a time: the sequencer is busy right after taking one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous one still in work");

  // a result is loaded only from the readout step, never while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a sample in work");

  // a request is still in work in the state after its first state in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##1 !s_axis_tready)
    else $error("request finished too fast");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind sliding_window_maximum_core swm_checker u_swm_checker (.*);
